// ===== rtl/core/assert_macros.svh =====
// assertion macros for the port-level checker file folu_checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// implication checked in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/folu_pkg.sv =====
// package for the frequency ordered list update block
// field widths, register reset value and sequencer states; no dependencies
package folu_pkg;

  // fixed widths of the stream fields
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned OUT_DATA_W = 2 * POS_W + CNT_OUT_W;

  // slots-in-use register
  localparam int unsigned     CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd7;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SEEK,
    ST_SHIFT,
    ST_PLACE
  } state_e;

endpackage

// ===== rtl/core/folu_table.sv =====
// table memory of keys and counts with one write and one registered read port
// per-entry valid bits make unwritten entries read as their reset value
module folu_table #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [COUNT_BITS-1:0] wr_cnt_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [COUNT_BITS-1:0] rd_cnt_o
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [DEPTH-1:0]      written_q;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic                  rd_written_q;
  logic [AW-1:0]         rd_addr_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    if (rd_en_i) begin
      rd_key_q  <= key_mem[rd_addr_i];
      rd_cnt_q  <= cnt_mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // valid bits, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // unwritten entry: key is the slot index, count zero
  assign rd_key_o = rd_written_q ? rd_key_q : KEY_BITS'(32'(rd_addr_q));
  assign rd_cnt_o = rd_written_q ? rd_cnt_q : '0;

endmodule

// ===== rtl/core/frequency_ordered_list_update.sv =====
// frequency ordered list update: one key per beat, one result beat per key.
// a hit at the head or with a saturated count is placed at once, any other hit seeks its
// target slot and shifts the entries between when it moves; a miss ends after the sweep
// of the slots in use. one key at a time, next key beat in the cycle after the result is
// loaded, set by the single table read port swept for the key, the target slot and the
// shift. reset: keys 0..DEPTH-1, zero counts, slots in use 7.
module frequency_ordered_list_update #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned KEY_BITS   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side, tdata: key[7:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [folu_pkg::KEY_W-1:0]        s_axis_tdata,
  // master side, tdata: old_position[3:0], new_position[7:4], new_count[23:8]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [folu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // master side, tuser: found[0]
  output logic                              m_axis_tuser,
  // slots-in-use register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [folu_pkg::CFG_W-1:0]        cfg_data_i
);

  import folu_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned UW = $clog2(DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_e state_q, state_d;

  logic [CFG_W-1:0]      cfg_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [UW-1:0]         used_q;
  logic [UW-1:0]         iss_q;
  logic [AW-1:0]         hit_q;
  logic [AW-1:0]         dest_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  sh_more_q;
  logic                  rd_vld_q;
  logic [AW-1:0]         rd_addr_q;

  logic                  m_valid_q;
  logic                  m_found_q;
  logic [POS_W-1:0]      m_old_q;
  logic [POS_W-1:0]      m_new_q;
  logic [CNT_OUT_W-1:0]  m_cnt_q;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;

  logic                  in_beat;
  logic                  out_free;
  logic                  find_match;
  logic                  find_miss;
  logic                  find_sat;
  logic                  seek_hit;
  logic                  seek_end;
  logic                  shift_done;
  logic                  out_load;
  logic [UW-1:0]         used_in;

  // table memory
  folu_table #(
    .DEPTH     (DEPTH),
    .KEY_BITS  (KEY_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_key_i (wr_key),
    .wr_cnt_i (wr_cnt),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_key_o (rd_key),
    .rd_cnt_o (rd_cnt)
  );

  // status terms
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign find_match = rd_vld_q && (rd_key == key_q);
  assign find_miss  = !rd_vld_q && (iss_q == used_q);
  assign find_sat   = (rd_cnt == CNT_MAX);
  assign seek_hit   = rd_vld_q && (rd_cnt <= cnt_q);
  assign seek_end   = !rd_vld_q && (iss_q == UW'(hit_q));
  assign shift_done = !sh_more_q && !rd_vld_q;
  assign used_in    = (32'(cfg_q) > DEPTH) ? UW'(DEPTH) : UW'(cfg_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) state_d = ST_FIND;
      end
      ST_FIND: begin
        if (find_match) begin
          state_d = (find_sat || (rd_addr_q == '0)) ? ST_PLACE : ST_SEEK;
        end else if (find_miss && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEEK: begin
        if (seek_hit) state_d = ST_SHIFT;
        else if (seek_end) state_d = ST_PLACE;
      end
      ST_SHIFT: begin
        if (shift_done) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory commands and handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = iss_q[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = rd_addr_q + AW'(1);
    wr_key        = rd_key;
    wr_cnt        = rd_cnt;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_FIND: begin
        rd_en    = (iss_q < used_q) && !find_match;
        out_load = !find_match && find_miss && out_free;
      end
      ST_SEEK: begin
        rd_en = (iss_q < UW'(hit_q)) && !seek_hit;
      end
      ST_SHIFT: begin
        rd_en = sh_more_q;
        wr_en = rd_vld_q;
      end
      ST_PLACE: begin
        wr_en    = out_free;
        wr_addr  = dest_q;
        wr_key   = key_q;
        wr_cnt   = cnt_q;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CFG_RESET;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // datapath registers of the item in work
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_addr_q <= rd_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          key_q  <= KEY_BITS'(32'(s_axis_tdata));
          used_q <= used_in;
          iss_q  <= '0;
        end
      end
      ST_FIND: begin
        if (find_match) begin
          hit_q  <= rd_addr_q;
          dest_q <= rd_addr_q;
          cnt_q  <= find_sat ? rd_cnt : rd_cnt + COUNT_BITS'(1);
          iss_q  <= '0;
        end else if (rd_en) begin
          iss_q <= iss_q + UW'(1);
        end
      end
      ST_SEEK: begin
        if (seek_hit) begin
          dest_q    <= rd_addr_q;
          iss_q     <= UW'(hit_q) - UW'(1);
          sh_more_q <= 1'b1;
        end else if (rd_en) begin
          iss_q <= iss_q + UW'(1);
        end
      end
      ST_SHIFT: begin
        // read downward from hit-1 to dest, each beat rewritten one slot back
        if (sh_more_q) begin
          if (iss_q[AW-1:0] == dest_q) sh_more_q <= 1'b0;
          else iss_q <= iss_q - UW'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_PLACE) begin
        m_found_q <= 1'b1;
        m_old_q   <= POS_W'(32'(hit_q));
        m_new_q   <= POS_W'(32'(dest_q));
        m_cnt_q   <= CNT_OUT_W'(32'(cnt_q));
      end else begin
        m_found_q <= 1'b0;
        m_old_q   <= '0;
        m_new_q   <= '0;
        m_cnt_q   <= '0;
      end
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {m_cnt_q, m_new_q, m_old_q};

endmodule

// ===== rtl/core/folu_checker.sv =====
// port-level checks for the frequency ordered list update block
// depends on folu_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module folu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [folu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // a miss reports all-zero fields
  `ASSERT_IMPL(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "miss beat carries nonzero fields")

  // one key in work at a time
  `ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "key accepted while another is in work")

endmodule

bind frequency_ordered_list_update folu_checker u_folu_checker (.*);

// ===== tb/folu_order_checker.sv =====
`timescale 1ns / 100ps
// checker for the frequency ordered list update block: watches the key, result
// and slots-in-use channels, keeps its own copy of the table and compares beats
// depends on folu_pkg for field widths and the register reset value
module folu_order_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // key channel, tdata: key[7:0]
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [folu_pkg::KEY_W-1:0]      s_axis_tdata,
  // result channel, tdata: old_position[3:0], new_position[7:4], new_count[23:8]
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [folu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // result channel, tuser: found[0]
  input  logic                            m_axis_tuser,
  // slots-in-use register write
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [folu_pkg::CFG_W-1:0]      cfg_data_i,
  output int                              errors_o,
  output int                              results_o,
  output int                              pending_o,
  output int                              hits_o,
  output logic [folu_pkg::KEY_W-1:0]      head_key_o
);

  localparam int unsigned PW = folu_pkg::POS_W;
  localparam int unsigned CW = folu_pkg::CNT_OUT_W;

  typedef struct packed {
    logic          found;
    logic [PW-1:0] old_pos;
    logic [PW-1:0] new_pos;
    logic [CW-1:0] count;
  } access_result_t;

  // shadow copy of the table and the register
  logic [folu_pkg::KEY_W-1:0] slot_key   [DEPTH];
  logic [CW-1:0]              slot_count [DEPTH];
  logic [folu_pkg::CFG_W-1:0] slots_in_use;

  access_result_t expected_results [$];

  assign head_key_o = slot_key[0];

  // find the key; unless saturated, bump its count and move it ahead of the first count not above it
  function automatic access_result_t predict_access(input logic [folu_pkg::KEY_W-1:0] key);
    int             used;
    int             hit;
    int             dest;
    int             j;
    bit             found;
    logic [CW-1:0]  cnt;
    logic [folu_pkg::KEY_W-1:0] moved;
    access_result_t res;
    res   = '0;
    found = 1'b0;
    hit   = 0;
    used  = int'(slots_in_use);
    if (used > DEPTH) used = DEPTH;
    for (j = 0; j < used; j++) begin
      if (!found && slot_key[j] == key) begin
        hit   = j;
        found = 1'b1;
      end
    end
    if (!found) return res;
    cnt  = slot_count[hit];
    dest = hit;
    // saturated count stays put
    if (cnt != '1) begin
      cnt = cnt + CW'(1);
      for (j = 0; j < hit; j++) begin
        if (dest == hit && slot_count[j] <= cnt) dest = j;
      end
    end
    moved = slot_key[hit];
    for (j = hit; j > dest; j--) begin
      slot_key[j]   = slot_key[j-1];
      slot_count[j] = slot_count[j-1];
    end
    slot_key[dest]   = moved;
    slot_count[dest] = cnt;
    res.found   = 1'b1;
    res.old_pos = hit[PW-1:0];
    res.new_pos = dest[PW-1:0];
    res.count   = cnt;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [CW-1:0] want,
                                      input logic [CW-1:0] got);
    if (got !== want) begin
      $display("%0t ns %s: expected %0d, got %0d", $time, name, want, got);
      errors_o++;
    end
  endfunction

  // beat monitor, all channels sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    access_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_key[i]   = i[folu_pkg::KEY_W-1:0];
        slot_count[i] = '0;
      end
      slots_in_use = folu_pkg::CFG_RESET;
      expected_results.delete();
      errors_o  = 0;
      results_o = 0;
      hits_o    = 0;
      pending_o = 0;
    end else begin
      // result beat
      if (m_axis_tvalid && m_axis_tready) begin
        got.found   = m_axis_tuser;
        got.old_pos = m_axis_tdata[PW-1:0];
        got.new_pos = m_axis_tdata[2*PW-1:PW];
        got.count   = m_axis_tdata[2*PW+CW-1:2*PW];
        results_o++;
        if (expected_results.size() == 0) begin
          $display("%0t ns result beat with none expected: found %0d old %0d new %0d count %0d",
                   $time, got.found, got.old_pos, got.new_pos, got.count);
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          if (want.found) hits_o++;
          check_field("found", CW'(want.found), CW'(got.found));
          check_field("old_position", CW'(want.old_pos), CW'(got.old_pos));
          check_field("new_position", CW'(want.new_pos), CW'(got.new_pos));
          check_field("new_count", want.count, got.count);
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_o) slots_in_use = cfg_data_i;
      // key beat
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_access(s_axis_tdata));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top for frequency_ordered_list_update: clock, reset, key stimulus,
// result back-pressure and the verdict; depends on folu_pkg and folu_order_checker
module tb;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [folu_pkg::KEY_W-1:0]      s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [folu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [folu_pkg::CFG_W-1:0]      cfg_data_i;

  int errors;
  int results_done;
  int outstanding;
  int hits;
  logic [folu_pkg::KEY_W-1:0] head_key;

  int keys_sent     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  frequency_ordered_list_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  folu_order_checker order_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .results_o     (results_done),
    .pending_o     (outstanding),
    .hits_o        (hits),
    .head_key_o    (head_key)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result back-pressure, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("frequency_ordered_list_update: mismatch");
    $finish;
  end

  // one key beat, with random gaps ahead of it
  task automatic send_key(input logic [folu_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    keys_sent++;
  endtask

  // block is idle once every key has its result beat
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_done < keys_sent) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [folu_pkg::CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly keys that live in the table, a few hot ones, some misses
  function automatic logic [folu_pkg::KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 8'($urandom_range(3));
    if (roll < 80) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_keys(input int count);
    repeat (count) send_key(pick_key());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting of seven slots
    send_key(8'd0);    // head hit stays at the head
    send_key(8'd3);    // equal count, jumps to the head
    send_key(8'd6);    // last slot in use
    send_key(8'd7);    // just past the slots in use
    send_key(8'd255);
    send_key(8'hAA);
    send_key(8'h55);
    send_key(8'd4);    // passes several entries
    send_key(8'd4);
    send_key(8'd4);
    send_key(8'd5);    // moves ahead of an equal count
    send_key(8'd5);    // no earlier entry small enough

    // no slots in use: every key misses
    write_slots(5'd0);
    send_key(8'd0);
    send_key(8'd3);

    // register above the table depth
    write_slots(5'd31);
    send_key(8'd15);
    send_key(8'd15);
    send_key(8'd10);

    write_slots(5'd16);
    send_key(8'd14);
    write_slots(5'd17);
    send_key(8'd15);
    write_slots(5'd1);
    send_key(head_key);
    send_key(8'd2);

    // random, sender gaps light, receiver gaps heavy
    send_idle_pct = 33;
    recv_idle_pct = 85;
    write_slots(5'd16);
    random_keys(600);

    // random, the other way round
    send_idle_pct = 85;
    recv_idle_pct = 33;
    write_slots(5'($urandom_range(2, 15)));
    random_keys(600);

    // no gaps, with a long receiver hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_slots(5'd12);
    hold_left = 300;
    random_keys(600);

    drain();
    repeat (80) @(posedge clk_i);
    $display("%0d keys sent, %0d found in the table, %0d result beats checked",
             keys_sent, hits, results_done);
    $display("slot settings 0, 1, 7, 12, 16, 17, 31 and a random one, with sender and");
    $display("receiver gaps both ways and one long result hold-off");
    if (errors == 0 && outstanding == 0) begin
      $display("frequency_ordered_list_update: match");
    end else begin
      $display("frequency_ordered_list_update: mismatch");
    end
    $finish;
  end

endmodule
